### hw/rtl/tts_pkg.sv
`default_nettype none

package tts_pkg;

  localparam int SLOTS = 16;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam int TIME_W = 48;
  localparam int TW_W = 32;
  localparam int BASE_W = 24;
  localparam int RETRY_W = 2;
  localparam int LIMIT_W = BASE_W + (1 << RETRY_W) - 1;

  localparam logic [TW_W-1:0] TIMEWAIT_RESET = 32'd2000000;
  localparam logic [BASE_W-1:0] BASE_RESET = 24'd200000;
  localparam logic [RETRY_W-1:0] GIVE_UP_RETRIES = 2'd3;

  localparam logic [2:0] FUNC_SCAN = 3'd0;
  localparam logic [2:0] FUNC_ARM_TW = 3'd1;
  localparam logic [2:0] FUNC_ARM_RT = 3'd2;
  localparam logic [2:0] FUNC_CANCEL_RT = 3'd3;
  localparam logic [2:0] FUNC_HEAD = 3'd4;

  localparam logic [2:0] ACT_NONE = 3'd0;
  localparam logic [2:0] ACT_TW_CLOSE = 3'd1;
  localparam logic [2:0] ACT_RETX = 3'd2;
  localparam logic [2:0] ACT_RESET = 3'd3;
  localparam logic [2:0] ACT_RT_CANCEL = 3'd4;

  localparam logic PHASE_TW = 1'b0;
  localparam logic PHASE_RT = 1'b1;

  typedef struct packed {
    logic [2:0] func;
    logic [3:0] slot;
    logic [TIME_W-1:0] now_us;
    logic head_present;
    logic [RETRY_W-1:0] head_retries;
  } in_word_t;

  typedef struct packed {
    logic [3:0] out_slot;
    logic [2:0] action;
    logic last_result;
  } out_word_t;

  typedef struct packed {
    logic cmd_write;
    logic scan_start;
    logic step_en;
    logic phase;
    logic [SLOT_W-1:0] idx;
    logic flush;
  } dp_cmd_t;

endpackage

`default_nettype wire

### hw/rtl/tts_cfg.sv
`default_nettype none

module tts_cfg (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic psel,
  input  wire logic penable,
  input  wire logic pwrite,
  input  wire logic [2:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready,
  output logic [tts_pkg::TW_W-1:0] timewait_us,
  output logic [tts_pkg::BASE_W-1:0] retrans_base_us
);

  logic [tts_pkg::TW_W-1:0] timewait_r;
  logic [tts_pkg::BASE_W-1:0] base_r;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timewait_r <= tts_pkg::TIMEWAIT_RESET;
      base_r <= tts_pkg::BASE_RESET;
    end else if (wr_en) begin
      if (paddr[2]) begin
        base_r <= pwdata[tts_pkg::BASE_W-1:0];
      end else begin
        timewait_r <= pwdata[tts_pkg::TW_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2]) begin
      prdata = {{(32 - tts_pkg::BASE_W){1'b0}}, base_r};
    end else begin
      prdata = timewait_r;
    end
  end

  assign timewait_us = timewait_r;
  assign retrans_base_us = base_r;

endmodule

`default_nettype wire

### hw/rtl/tts_ctrl.sv
`default_nettype none

module tts_ctrl (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  input  wire logic [2:0] func,
  output logic busy,
  output tts_pkg::dp_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;
  localparam logic [tts_pkg::SLOT_W-1:0] LAST_IDX = tts_pkg::SLOT_W'(tts_pkg::SLOTS - 1);

  logic [1:0] state_r, state_nxt;
  logic [tts_pkg::SLOT_W-1:0] idx_r, idx_nxt;
  logic phase_r, phase_nxt;
  logic accept;

  assign busy = (state_r != ST_IDLE);
  assign accept = start && !busy;

  always_comb begin
    state_nxt = state_r;
    idx_nxt = idx_r;
    phase_nxt = phase_r;
    cmd = '0;
    cmd.idx = idx_r;
    cmd.phase = phase_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (func == tts_pkg::FUNC_SCAN) begin
            cmd.scan_start = 1'b1;
            state_nxt = ST_SCAN;
            idx_nxt = '0;
            phase_nxt = tts_pkg::PHASE_TW;
          end else begin
            cmd.cmd_write = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        cmd.step_en = 1'b1;
        phase_nxt = ~phase_r;
        if (phase_r == tts_pkg::PHASE_RT) begin
          if (idx_r == LAST_IDX) begin
            state_nxt = ST_FLUSH;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        cmd.flush = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r <= '0;
      phase_r <= tts_pkg::PHASE_TW;
    end else begin
      state_r <= state_nxt;
      idx_r <= idx_nxt;
      phase_r <= phase_nxt;
    end
  end

`ifndef SYNTHESIS
  a_flush_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FLUSH |=> state_r == ST_IDLE)
    else $error("Flush state did not return to idle.");

  a_scan_begins_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && func == tts_pkg::FUNC_SCAN) |=>
      (state_r == ST_SCAN && idx_r == '0 && phase_r == tts_pkg::PHASE_TW))
    else $error("Scan did not begin at the first slot.");

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> 32'(idx_r) < tts_pkg::SLOTS)
    else $error("Scan index out of range.");
`endif

endmodule

`default_nettype wire

### hw/rtl/tts_dp.sv
`default_nettype none

module tts_dp (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire tts_pkg::dp_cmd_t cmd,
  input  wire tts_pkg::in_word_t in_word,
  input  wire logic [tts_pkg::TW_W-1:0] timewait_us,
  input  wire logic [tts_pkg::BASE_W-1:0] retrans_base_us,
  output logic out_valid,
  output tts_pkg::out_word_t out_word
);

  logic [tts_pkg::SLOTS-1:0] tw_armed_r;
  logic [tts_pkg::SLOTS-1:0] rt_armed_r;
  logic [tts_pkg::SLOTS-1:0] head_valid_r;
  logic [tts_pkg::RETRY_W-1:0] retry_r [tts_pkg::SLOTS];
  logic [tts_pkg::TIME_W-1:0] tw_start_r [tts_pkg::SLOTS];
  logic [tts_pkg::TIME_W-1:0] rt_start_r [tts_pkg::SLOTS];

  logic [tts_pkg::TIME_W-1:0] scan_now_r;
  logic pend_valid_r;
  tts_pkg::out_word_t pend_r;
  logic out_valid_r;
  tts_pkg::out_word_t out_word_r;

  logic slot_ok;
  logic [tts_pkg::SLOT_W-1:0] wslot;
  logic [tts_pkg::SLOT_W-1:0] idx;
  logic [tts_pkg::RETRY_W-1:0] cur_retry;
  logic [tts_pkg::LIMIT_W-1:0] rt_limit;
  logic [tts_pkg::TIME_W-1:0] cmp_start;
  logic [tts_pkg::TIME_W-1:0] cmp_limit;
  logic [tts_pkg::TIME_W-1:0] cmp_diff;
  logic expired;
  logic new_valid;
  logic [2:0] new_action;

  assign slot_ok = 32'(in_word.slot) < tts_pkg::SLOTS;
  assign wslot = tts_pkg::SLOT_W'(in_word.slot);
  assign idx = cmd.idx;
  assign cur_retry = retry_r[idx];
  assign rt_limit = tts_pkg::LIMIT_W'(retrans_base_us) << cur_retry;

  always_comb begin
    if (cmd.phase == tts_pkg::PHASE_TW) begin
      cmp_start = tw_start_r[idx];
      cmp_limit = tts_pkg::TIME_W'(timewait_us);
    end else begin
      cmp_start = rt_start_r[idx];
      cmp_limit = tts_pkg::TIME_W'(rt_limit);
    end
    cmp_diff = scan_now_r - cmp_start;
    expired = (scan_now_r >= cmp_start) && (cmp_diff > cmp_limit);
  end

  always_comb begin
    new_valid = 1'b0;
    new_action = tts_pkg::ACT_NONE;
    if (cmd.step_en) begin
      if (cmd.phase == tts_pkg::PHASE_TW) begin
        if (tw_armed_r[idx] && expired) begin
          new_valid = 1'b1;
          new_action = tts_pkg::ACT_TW_CLOSE;
        end
      end else if (rt_armed_r[idx]) begin
        if (!head_valid_r[idx]) begin
          new_valid = 1'b1;
          new_action = tts_pkg::ACT_RT_CANCEL;
        end else if (expired) begin
          new_valid = 1'b1;
          if (cur_retry == tts_pkg::GIVE_UP_RETRIES) begin
            new_action = tts_pkg::ACT_RESET;
          end else begin
            new_action = tts_pkg::ACT_RETX;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tw_armed_r <= '0;
      rt_armed_r <= '0;
      head_valid_r <= '0;
      for (int i = 0; i < tts_pkg::SLOTS; i++) begin
        retry_r[i] <= '0;
      end
    end else if (cmd.cmd_write && slot_ok) begin
      case (in_word.func)
        tts_pkg::FUNC_ARM_TW: begin
          tw_armed_r[wslot] <= 1'b1;
        end
        tts_pkg::FUNC_ARM_RT: begin
          rt_armed_r[wslot] <= 1'b1;
        end
        tts_pkg::FUNC_CANCEL_RT: begin
          rt_armed_r[wslot] <= 1'b0;
        end
        tts_pkg::FUNC_HEAD: begin
          head_valid_r[wslot] <= in_word.head_present;
          retry_r[wslot] <= in_word.head_retries;
        end
        default: begin
        end
      endcase
    end else if (new_valid) begin
      case (new_action)
        tts_pkg::ACT_TW_CLOSE: begin
          tw_armed_r[idx] <= 1'b0;
        end
        tts_pkg::ACT_RETX: begin
          retry_r[idx] <= cur_retry + 1'b1;
        end
        default: begin
          rt_armed_r[idx] <= 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cmd_write && slot_ok) begin
      if (in_word.func == tts_pkg::FUNC_ARM_TW) begin
        tw_start_r[wslot] <= in_word.now_us;
      end
      if (in_word.func == tts_pkg::FUNC_ARM_RT && !rt_armed_r[wslot]) begin
        rt_start_r[wslot] <= in_word.now_us;
      end
    end else if (new_valid && new_action == tts_pkg::ACT_RETX) begin
      rt_start_r[idx] <= scan_now_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      scan_now_r <= in_word.now_us;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cmd.scan_start) begin
        pend_valid_r <= 1'b0;
      end else if (new_valid) begin
        out_valid_r <= pend_valid_r;
        pend_valid_r <= 1'b1;
      end else if (cmd.flush) begin
        out_valid_r <= pend_valid_r;
        pend_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (new_valid) begin
      out_word_r <= '{out_slot: pend_r.out_slot, action: pend_r.action, last_result: 1'b0};
      pend_r.out_slot <= 4'(idx);
      pend_r.action <= new_action;
      pend_r.last_result <= 1'b0;
    end else if (cmd.flush) begin
      out_word_r <= '{out_slot: pend_r.out_slot, action: pend_r.action, last_result: 1'b1};
    end
  end

  assign out_valid = out_valid_r;
  assign out_word = out_word_r;

`ifndef SYNTHESIS
  a_action_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_word_r.action != tts_pkg::ACT_NONE)
    else $error("Result issued with no action.");

  a_flush_last: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.flush && pend_valid_r) |=> (out_valid_r && out_word_r.last_result))
    else $error("Final result of a scan was not marked last.");
`endif

endmodule

`default_nettype wire

### hw/rtl/tcp_timer_table_scan.sv
`default_nettype none

// Timer table for a fixed set of connection slots, each with a time-wait
// timer and a retransmission timer with exponential backoff.
// Input words are taken when start is high and busy is low. A command word
// (arm, cancel, head update) is applied at that edge and busy stays low, so
// commands can follow back to back at one word per cycle.
// A scan word raises busy for the whole scan: the sequencer visits each slot
// in index order, checking the time-wait timer and then the retransmission
// timer through one shared subtract and compare unit, and a final flush
// state releases the last result.
// Result words appear on out_word for one cycle with out_valid high, in slot
// order, and the word with last_result set ends the scan. Each result is
// held until the next one is known or the scan ends, and only then leaves.
// A scan that finds nothing gives no result.
// The receiver cannot stall the result channel.
// Configuration registers are on the APB port: time-wait hold time at 0 and
// retransmission base interval at 4. They are to be written only while idle;
// the block itself does not enforce this. Reset disarms all timers, clears
// head status and retry counts, and loads the register defaults.
module tcp_timer_table_scan (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic busy,
  input  wire tts_pkg::in_word_t in_word,
  output logic out_valid,
  output tts_pkg::out_word_t out_word,
  input  wire logic psel,
  input  wire logic penable,
  input  wire logic pwrite,
  input  wire logic [2:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);

  tts_pkg::dp_cmd_t cmd;
  logic [tts_pkg::TW_W-1:0] timewait_us;
  logic [tts_pkg::BASE_W-1:0] retrans_base_us;

  tts_cfg u_cfg (
    .clk (clk),
    .rst_n (rst_n),
    .psel (psel),
    .penable (penable),
    .pwrite (pwrite),
    .paddr (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .timewait_us (timewait_us),
    .retrans_base_us (retrans_base_us)
  );

  tts_ctrl u_ctrl (
    .clk (clk),
    .rst_n (rst_n),
    .start (start),
    .func (in_word.func),
    .busy (busy),
    .cmd (cmd)
  );

  tts_dp u_dp (
    .clk (clk),
    .rst_n (rst_n),
    .cmd (cmd),
    .in_word (in_word),
    .timewait_us (timewait_us),
    .retrans_base_us (retrans_base_us),
    .out_valid (out_valid),
    .out_word (out_word)
  );

endmodule

`default_nettype wire
